// ===== design/ordered_list_append_delete_assert.svh =====
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define OLAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition never seen at a clock edge outside reset
`define OLAD_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define OLAD_ASSERT(lbl, clk, rstn, prop, msg)
`define OLAD_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

// ===== design/olad_pkg.sv =====
// shared types and codes of the ordered list block
package olad_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_OW = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    logic              append;
    logic              cmp;
    logic              del;
    logic              rot;
    logic [DATA_W-1:0] wdata;
  } olad_cmd_t;

  // where a cell stands relative to the current fill
  typedef struct packed {
    logic in_use;
    logic tail_slot;
    logic last_used;
  } olad_pos_t;

endpackage

// ===== design/olad_cell.sv =====
// one list slot: holds an entry, compares, and takes its neighbor's entry on shift
module olad_cell (
  input  logic                           clk_i,
  input  olad_pkg::olad_cmd_t            cmd_i,
  input  olad_pkg::olad_pos_t            pos_i,
  input  logic [olad_pkg::DATA_W-1:0]    next_i,
  input  logic [olad_pkg::DATA_W-1:0]    head_i,
  input  logic                           hit_i,
  output logic [olad_pkg::DATA_W-1:0]    val_o,
  output logic                           hit_o
);

  logic [olad_pkg::DATA_W-1:0] val_q;
  logic                        match_q;

  // a hit here or in any earlier slot moves this slot up by one
  assign hit_o = hit_i | match_q;
  assign val_o = val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      match_q <= pos_i.in_use & (val_q == cmd_i.wdata);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && pos_i.tail_slot) begin
      val_q <= cmd_i.wdata;
    end else if (cmd_i.del && hit_o && pos_i.in_use && !pos_i.last_used) begin
      val_q <= next_i;
    end else if (cmd_i.rot && pos_i.in_use) begin
      // rotate the used part of the row: tail slot wraps to the head entry
      val_q <= pos_i.last_used ? head_i : next_i;
    end
  end

endmodule

// ===== design/ordered_list_append_delete.sv =====
// top level of the ordered list block: a row of slot cells plus the operation sequencer
// append, unused opcode and empty dump: a single beat in the cycle after start, next start at once
// delete: compare on start, then shift in the delete state; result registered from it, next start once back in idle
// dump: one entry a cycle from the head as the row rotates, the first registered from the dump state after start
// reset clears fill count, sequencer and result strobe; slots hold garbage until written
// results are single-cycle beats on result_valid_o, cannot be stalled; busy holds through the dump
`include "ordered_list_append_delete_assert.svh"

module ordered_list_append_delete #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode_i,
  input  logic signed [olad_pkg::DATA_W-1:0]   value_i,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic signed [olad_pkg::DATA_W-1:0]   entry_value_o,
  output logic                                 is_last_o,
  output logic [olad_pkg::COUNT_OW-1:0]        entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;

  // result beat register
  logic                          valid_q, valid_d;
  logic [1:0]                    status_q, status_d;
  logic [olad_pkg::DATA_W-1:0]   evalue_q, evalue_d;
  logic                          last_q, last_d;
  logic [CW-1:0]                 ocount_q, ocount_d;

  logic                accept;
  logic                full;
  logic                found;
  logic                dump_last;
  olad_pkg::olad_cmd_t cmd;

  logic [olad_pkg::DATA_W-1:0] vals [CAPACITY];
  logic                        hits [CAPACITY+1];

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;
  assign full   = (count_q == CW'(CAPACITY));
  assign found  = hits[CAPACITY];
  // current dump beat is the tail entry
  assign dump_last = (CW'(idx_q + CW'(1)) == count_q);

  // broadcast command to the cell row
  always_comb begin
    cmd.append = accept & (opcode_i == olad_pkg::OP_APPEND) & ~full;
    cmd.cmp    = accept & (opcode_i == olad_pkg::OP_DELETE);
    cmd.del    = (state_q == ST_DEL) & found;
    cmd.rot    = (state_q == ST_DUMP);
    cmd.wdata  = value_i;
  end

  // the cell row; no slot before the head, so the hit chain starts clear
  assign hits[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olad_pkg::olad_pos_t         pos;
    logic [olad_pkg::DATA_W-1:0] nxt;

    assign pos.in_use    = (CW'(i) < count_q);
    assign pos.tail_slot = (count_q == CW'(i));
    assign pos.last_used = (count_q == CW'(i + 1));

    // the last slot has no neighbor behind it
    if (i == CAPACITY - 1) begin : g_end
      assign nxt = vals[i];
    end else begin : g_mid
      assign nxt = vals[i+1];
    end

    olad_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (pos),
      .next_i (nxt),
      .head_i (vals[0]),
      .hit_i  (hits[i]),
      .val_o  (vals[i]),
      .hit_o  (hits[i+1])
    );
  end

  // sequencer and result beat
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    valid_d  = 1'b0;
    status_d = olad_pkg::STAT_OK;
    evalue_d = '0;
    last_d   = 1'b1;
    ocount_d = count_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            olad_pkg::OP_APPEND: begin
              valid_d = 1'b1;
              if (full) begin
                status_d = olad_pkg::STAT_FULL;
              end else begin
                count_d  = CW'(count_q + CW'(1));
                ocount_d = count_d;
              end
            end
            olad_pkg::OP_DELETE: begin
              // slots latch their match bits this edge
              state_d = ST_DEL;
            end
            olad_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = olad_pkg::STAT_EMPTY;
              end else begin
                state_d = ST_DUMP;
                idx_d   = '0;
              end
            end
            default: begin
              // unused opcode: plain ok beat
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_DEL: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (found) begin
          count_d  = CW'(count_q - CW'(1));
          ocount_d = count_d;
        end else begin
          status_d = olad_pkg::STAT_NOTFOUND;
        end
      end
      ST_DUMP: begin
        // head slot is emitted while the row rotates one place
        valid_d  = 1'b1;
        evalue_d = vals[0];
        last_d   = dump_last;
        if (dump_last) begin
          state_d = ST_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = CW'(idx_q + CW'(1));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    evalue_q <= evalue_d;
    last_q   <= last_d;
    ocount_q <= ocount_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign entry_value_o  = evalue_q;
  assign is_last_o      = last_q;
  assign entry_count_o  = olad_pkg::COUNT_OW'(ocount_q);

  `OLAD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "fill count above capacity")
  `OLAD_ASSERT(a_append_grows, clk_i, rst_ni, (accept && opcode_i == olad_pkg::OP_APPEND && !full) |=> (count_q == CW'($past(count_q) + CW'(1))), "append did not grow the list")
  `OLAD_ASSERT(a_dump_streams, clk_i, rst_ni, (state_q == ST_DUMP) |=> result_valid_o, "dump cycle without a result beat")
  `OLAD_ASSERT(a_miss_keeps, clk_i, rst_ni, (state_q == ST_DEL && !found) |=> (count_q == $past(count_q) && status_o == olad_pkg::STAT_NOTFOUND), "missed delete changed the list")
  `OLAD_ASSERT_NEVER(a_busy_idle_beat, clk_i, rst_ni, state_q == ST_DEL && $past(state_q) == ST_DEL, "delete compare stuck")

endmodule
